>>> rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants for the TLB page table translator
// Field widths of the address and result ports and the controller states.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int OFFSET_BITS = 8;
  localparam int RAW_PAGE_W  = ADDR_W - OFFSET_BITS;
  localparam int RAW_PAGES   = 1 << RAW_PAGE_W;
  localparam int FRAME_W     = 8;
  localparam int HIT_CNT_W   = 16;
  localparam int FAULT_CNT_W = 9;

  localparam logic [HIT_CNT_W-1:0]   HIT_MAX   = '1;
  localparam logic [FAULT_CNT_W-1:0] FAULT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_LOOKUP = 2'b10
  } state_t;

endpackage

>>> rtl/tlb_page_table_translate_top.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translate_top: TLB-fronted demand-paging address translator
// LRU TLB in slot registers, page table in a synchronous frame memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive logical_address and raise start; the address
//   transfers at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle and carries
//   physical_address, frame_number, tlb_hit, page_fault, tlb_hit_count and
//   fault_count. The receiver cannot stall; it must take the result then.
// Timing:
//   Transfer edge: the page index is looked up in a constant modulo table
//   and the frame memory is read into a registered output.
//   Lookup state: TLB compare, frame select, page table and TLB update; the
//   result registers and done load as the lookup state ends.
//   busy is high for one cycle after each transfer, so a new address is
//   taken only once the lookup state has ended.
//   The frame memory write lands before the next read can be issued, so no
//   forwarding is needed.
// Reset:
//   rst (synchronous, active high) empties the TLB, clears all page valid
//   bits, the free frame pointer and both counters. No clearing pass runs;
//   the block accepts an address as soon as rst is released.
// ----------------------------------------------------------------------------
module tlb_page_table_translate_top #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tlbpt_pkg::ADDR_W-1:0]         logical_address,
  output logic                                 done,
  output logic [tlbpt_pkg::ADDR_W-1:0]         physical_address,
  output logic [tlbpt_pkg::FRAME_W-1:0]        frame_number,
  output logic                                 tlb_hit,
  output logic                                 page_fault,
  output logic [tlbpt_pkg::HIT_CNT_W-1:0]      tlb_hit_count,
  output logic [tlbpt_pkg::FAULT_CNT_W-1:0]    fault_count
);

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int FILL_W = $clog2(TLB_ENTRIES + 1);
  localparam int NFF_W  = $clog2(FRAME_COUNT + 1);
  localparam int RAW_W  = tlbpt_pkg::RAW_PAGE_W;
  localparam int RAWS   = tlbpt_pkg::RAW_PAGES;
  localparam int OFF_W  = tlbpt_pkg::OFFSET_BITS;
  localparam int FR_W   = tlbpt_pkg::FRAME_W;

  // Raw page number reduced modulo the page count, built at elaboration.
  function automatic logic [RAWS*PAGE_W-1:0] build_mod_tab();
    logic [RAWS*PAGE_W-1:0] tab;
    tab = '0;
    for (int i = 0; i < RAWS; i++) begin
      tab[i*PAGE_W +: PAGE_W] = PAGE_W'(i % PAGE_COUNT);
    end
    return tab;
  endfunction

  localparam logic [RAWS*PAGE_W-1:0] MOD_TAB = build_mod_tab();

  tlbpt_pkg::state_t state, state_next;

  logic                   accept;
  logic                   lookup;
  logic [RAW_W-1:0]       pg_raw;
  logic [PAGE_W-1:0]      pg_in;
  logic [PAGE_W-1:0]      pg_q;
  logic [OFF_W-1:0]       off_q;

  logic [FR_W-1:0]        frame_mem [PAGE_COUNT];
  logic [FR_W-1:0]        mem_rd;
  logic [PAGE_COUNT-1:0]  page_valid;

  logic [PAGE_W-1:0]      tlb_tag   [TLB_ENTRIES];
  logic [FR_W-1:0]        tlb_frame [TLB_ENTRIES];
  logic [PAGE_W-1:0]      tag_src   [TLB_ENTRIES];
  logic [FR_W-1:0]        frame_src [TLB_ENTRIES];
  logic [FILL_W-1:0]      tlb_fill;
  logic [TLB_ENTRIES-1:0] tlb_match;
  logic [TLB_ENTRIES-1:0] at_or_after;
  logic [TLB_ENTRIES-1:0] shift_en;
  logic [FR_W-1:0]        hit_frame;
  logic                   hit;
  logic                   full;
  logic [FILL_W-1:0]      ins_slot;

  logic [NFF_W-1:0]       next_free_frame;
  logic [NFF_W-1:0]       alloc_frame;
  logic                   fault;
  logic [FR_W-1:0]        fr_sel;

  logic [tlbpt_pkg::HIT_CNT_W-1:0]   hit_total;
  logic [tlbpt_pkg::HIT_CNT_W-1:0]   hit_total_next;
  logic [tlbpt_pkg::FAULT_CNT_W-1:0] fault_total;
  logic [tlbpt_pkg::FAULT_CNT_W-1:0] fault_total_next;

  assign accept = start && (state == tlbpt_pkg::S_IDLE);
  assign lookup = (state == tlbpt_pkg::S_LOOKUP);
  assign busy   = lookup;

  assign pg_raw = logical_address[tlbpt_pkg::ADDR_W-1 -: RAW_W];
  assign pg_in  = MOD_TAB[pg_raw*PAGE_W +: PAGE_W];

  always_comb begin
    state_next = state;
    case (state)
      tlbpt_pkg::S_IDLE:   if (start) state_next = tlbpt_pkg::S_LOOKUP;
      tlbpt_pkg::S_LOOKUP: state_next = tlbpt_pkg::S_IDLE;
      default:             state_next = tlbpt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request and issue the frame memory read at transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      pg_q  <= pg_in;
      off_q <= logical_address[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (lookup && fault) begin
      frame_mem[pg_q] <= fr_sel;
    end
    if (accept) begin
      mem_rd <= frame_mem[pg_in];
    end
  end

  // TLB compare across occupied slots; tags are unique, so at most one hits.
  always_comb begin
    logic run;
    tlb_match   = '0;
    at_or_after = '0;
    hit_frame   = '0;
    run         = 1'b0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      if ((FILL_W'(k) < tlb_fill) && (tlb_tag[k] == pg_q)) begin
        tlb_match[k] = 1'b1;
        hit_frame    = hit_frame | tlb_frame[k];
      end
      run            = run | tlb_match[k];
      at_or_after[k] = run;
    end
  end

  assign hit      = |tlb_match;
  assign full     = (tlb_fill == FILL_W'(TLB_ENTRIES));
  assign shift_en = hit ? at_or_after : {TLB_ENTRIES{full}};
  assign ins_slot = (hit || full) ? tlb_fill - FILL_W'(1) : tlb_fill;

  assign fault       = !hit && !page_valid[pg_q];
  // Wrap the free frame pointer before allocating once frames run out.
  assign alloc_frame = (next_free_frame == NFF_W'(FRAME_COUNT)) ? '0 : next_free_frame;

  always_comb begin
    if (hit) begin
      fr_sel = hit_frame;
    end else if (page_valid[pg_q]) begin
      fr_sel = mem_rd;
    end else begin
      fr_sel = FR_W'(alloc_frame);
    end
  end

  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_src
    if (k < TLB_ENTRIES - 1) begin : g_next
      assign tag_src[k]   = tlb_tag[k+1];
      assign frame_src[k] = tlb_frame[k+1];
    end else begin : g_last
      assign tag_src[k]   = tlb_tag[k];
      assign frame_src[k] = tlb_frame[k];
    end
  end

  // Shift newer entries toward slot 0 and append the access as newest.
  always_ff @(posedge clk) begin
    if (lookup) begin
      for (int k = 0; k < TLB_ENTRIES; k++) begin
        if (FILL_W'(k) == ins_slot) begin
          tlb_tag[k]   <= pg_q;
          tlb_frame[k] <= fr_sel;
        end else if (shift_en[k]) begin
          tlb_tag[k]   <= tag_src[k];
          tlb_frame[k] <= frame_src[k];
        end
      end
    end
  end

  assign hit_total_next = (hit && (hit_total != tlbpt_pkg::HIT_MAX)) ?
                          hit_total + tlbpt_pkg::HIT_CNT_W'(1) : hit_total;
  assign fault_total_next = (fault && (fault_total != tlbpt_pkg::FAULT_MAX)) ?
                            fault_total + tlbpt_pkg::FAULT_CNT_W'(1) : fault_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_fill        <= '0;
      page_valid      <= '0;
      next_free_frame <= '0;
      hit_total       <= '0;
      fault_total     <= '0;
      done            <= 1'b0;
    end else begin
      done <= lookup;
      if (lookup) begin
        hit_total   <= hit_total_next;
        fault_total <= fault_total_next;
        if (!hit && !full) begin
          tlb_fill <= tlb_fill + FILL_W'(1);
        end
        if (fault) begin
          page_valid[pg_q] <= 1'b1;
          next_free_frame  <= alloc_frame + NFF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      physical_address <= {fr_sel, off_q};
      frame_number     <= fr_sel;
      tlb_hit          <= hit;
      page_fault       <= fault;
      tlb_hit_count    <= hit_total_next;
      fault_count      <= fault_total_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_lookup: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding lookup cycle");

  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("lookup lasted more than one cycle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not start a lookup");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    tlb_fill <= FILL_W'(TLB_ENTRIES))
    else $error("TLB fill count beyond capacity");

  a_hit_not_fault: assert property (@(posedge clk) disable iff (rst)
    done |-> !(tlb_hit && page_fault))
    else $error("TLB hit reported together with a page fault");
`endif

endmodule
